>>> sv/mst_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the membership set table.
// No dependencies; used by mst_cell and membership_set_table_unit.
package mst_pkg;

    localparam int KEY_FIELD_W   = 32;
    localparam int COUNT_FIELD_W = 5;
    localparam int REQ_W         = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    // Strobes broadcast to every cell of the row
    typedef struct packed {
        logic cmp;  // register the compare against the broadcast key
        logic rm;   // remove: cells at or after the match take the next key
        logic ins;  // insert: the tail cell loads the broadcast key
    } t_cell_ctl;

endpackage

>>> sv/mst_cell.sv
`timescale 1ns / 1ps
// One slot of the key row: holds a key, compares it and shifts it down.
// Depends on mst_pkg.
module mst_cell #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mst_pkg::t_cell_ctl    i_ctl,
    input  logic [KEY_WIDTH-1:0]  i_key,
    input  logic                  i_occ,
    input  logic                  i_tail,
    input  logic [KEY_WIDTH-1:0]  i_nxt_key,
    input  logic                  i_after,
    output logic                  o_after,
    output logic                  o_match,
    output logic [KEY_WIDTH-1:0]  o_key
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    logic                 r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_match <= i_occ && (r_key == i_key);
        end
    end

    // at or after the matching slot
    assign o_after = i_after | r_match;
    assign o_match = r_match;
    assign o_key   = r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctl.rm && o_after) begin
            n_key = i_nxt_key;
        end else if (i_ctl.ins && i_tail) begin
            n_key = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

>>> sv/membership_set_table_unit.sv
`timescale 1ns / 1ps
// Each request passes a compare state, then an update state that registers the result.
// A new request is taken while idle or during the previous update, never during its compare.
// A held result does not block the next request; the update waits only while the
// output register is full and stalled.
// Reset clears the entry count and control state; stored keys are not cleared.
// Depends on mst_pkg and mst_cell.
module membership_set_table_unit #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [mst_pkg::REQ_W-1:0]          i_req_type,
    input  logic [mst_pkg::KEY_FIELD_W-1:0]    i_key,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_hit,
    output logic                               o_full_refused,
    output logic [mst_pkg::COUNT_FIELD_W-1:0]  o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [mst_pkg::REQ_W-1:0] r_req;
    logic [KEY_WIDTH-1:0]      r_key;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic                      r_out_valid;
    logic                      r_hit;
    logic                      r_ref;
    logic [CW-1:0]             r_out_count;

    logic                      w_out_free;
    logic                      w_in_acc;
    logic                      w_upd;
    logic                      w_found;
    logic                      w_full;
    logic                      w_ins_ok;
    logic                      w_rm_ok;
    logic                      w_hit;
    logic                      w_ref;
    mst_pkg::t_cell_ctl        w_ctl;
    logic [CAPACITY:0]         w_after;
    logic [CAPACITY-1:0]       w_match;
    logic [KEY_WIDTH-1:0]      w_row_key [CAPACITY+1];

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) || ((r_state == ST_UPD) && w_out_free));
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_upd      = (r_state == ST_UPD) && w_out_free;

    assign w_found  = w_after[CAPACITY];
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_ins_ok = (r_req == mst_pkg::REQ_INSERT) && !w_found && !w_full;
    assign w_rm_ok  = (r_req == mst_pkg::REQ_REMOVE) && w_found;
    assign w_ref    = (r_req == mst_pkg::REQ_INSERT) && !w_found && w_full;

    always_comb begin
        case (r_req)
            mst_pkg::REQ_INSERT: w_hit = w_ins_ok;
            mst_pkg::REQ_REMOVE: w_hit = w_found;
            mst_pkg::REQ_QUERY:  w_hit = w_found;
            default:             w_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_rm_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_ctl.cmp = (r_state == ST_CMP);
    assign w_ctl.rm  = w_upd && w_rm_ok;
    assign w_ctl.ins = w_upd && w_ins_ok;

    // the cell row
    assign w_after[0]          = 1'b0;
    assign w_row_key[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        mst_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_key     (r_key),
            .i_occ     (CW'(g) < r_count),
            .i_tail    (CW'(g) == r_count),
            .i_nxt_key (w_row_key[g+1]),
            .i_after   (w_after[g]),
            .o_after   (w_after[g+1]),
            .o_match   (w_match[g]),
            .o_key     (w_row_key[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_acc) n_state = ST_CMP;
            ST_CMP:  n_state = ST_UPD;
            ST_UPD: begin
                if (w_upd) begin
                    n_state = w_in_acc ? ST_CMP : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_upd) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req <= i_req_type;
            r_key <= KEY_WIDTH'(i_key);
        end
        if (w_upd) begin
            r_hit       <= w_hit;
            r_ref       <= w_ref;
            r_out_count <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_full_refused = r_ref;
    assign o_entry_count  = mst_pkg::COUNT_FIELD_W'(r_out_count);

    // keys held are distinct, so at most one slot may match
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> $onehot0(w_match))
        else $error("more than one slot matched the key");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_upd |=> (r_count == $past(r_count)))
        else $error("entry count moved outside an update");

    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_CMP))
        else $error("accepted request did not enter compare");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_full_refused))
        else $error("hit and refusal both set");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for membership_set_table_unit: directed table then random requests.
// Depends on mst_pkg and the table unit; predicts each result from its own key list unless a row gives it.
module tb;

    localparam int TABLE_DEPTH  = 16;
    localparam int KEY_POOL_N   = 22;  // more than the depth, so the table fills up
    localparam int RANDOM_ITEMS = 1450;
    localparam int CALM_TAIL    = 150;
    localparam int LONG_HOLD    = 300;
    localparam int DIRECTED_N   = 22;
    localparam logic [mst_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;  // unused code, must be ignored

    typedef struct packed {
        logic                              hit;
        logic                              refused;
        logic [mst_pkg::COUNT_FIELD_W-1:0] count;
    } t_set_result;

    typedef struct {
        logic [mst_pkg::REQ_W-1:0]       req;
        logic [mst_pkg::KEY_FIELD_W-1:0] key;
        int                              span;   // consecutive keys from key upwards
        bit                              typed;  // result given in the row
        t_set_result                     res;
    } t_stim_row;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic [mst_pkg::REQ_W-1:0]         i_req_type;
    logic [mst_pkg::KEY_FIELD_W-1:0]   i_key;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic                              o_hit;
    logic                              o_full_refused;
    logic [mst_pkg::COUNT_FIELD_W-1:0] o_entry_count;

    logic [mst_pkg::KEY_FIELD_W-1:0] held_keys[$];
    t_set_result                     set_results_due[$];
    int                              bad_results;
    int                              requests_taken;
    bit                              calm;
    bit                              in_long_hold;
    bit                              tx_bursty;

    membership_set_table_unit #(
        .CAPACITY  (TABLE_DEPTH),
        .KEY_WIDTH (mst_pkg::KEY_FIELD_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_key          (i_key),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_full_refused (o_full_refused),
        .o_entry_count  (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Updates the held key list and returns the result the request should give.
    function automatic t_set_result apply_set_request(
        input logic [mst_pkg::REQ_W-1:0]       req,
        input logic [mst_pkg::KEY_FIELD_W-1:0] key);
        t_set_result r;
        int          pos;
        pos = -1;
        foreach (held_keys[i])
            if (pos < 0 && held_keys[i] == key) pos = i;
        r.hit     = 1'b0;
        r.refused = 1'b0;
        case (req)
            mst_pkg::REQ_INSERT: begin
                if (pos < 0) begin
                    if (held_keys.size() < TABLE_DEPTH) begin
                        held_keys.push_back(key);
                        r.hit = 1'b1;
                    end else begin
                        r.refused = 1'b1;
                    end
                end
            end
            mst_pkg::REQ_REMOVE: begin
                if (pos >= 0) begin
                    held_keys.delete(pos);  // later entries close the gap
                    r.hit = 1'b1;
                end
            end
            mst_pkg::REQ_QUERY: r.hit = (pos >= 0);
            default: ;
        endcase
        r.count = mst_pkg::COUNT_FIELD_W'(held_keys.size());
        return r;
    endfunction

    task automatic offer_request(input logic [mst_pkg::REQ_W-1:0]       req,
                                 input logic [mst_pkg::KEY_FIELD_W-1:0] key,
                                 input bit typed, input t_set_result typed_res);
        int          gap;
        t_set_result r;
        gap = 0;
        if (!calm && !in_long_hold && tx_bursty && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 18);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_key      <= key;
        do @(posedge i_clk); while (o_in_stall);
        r = apply_set_request(req, key);
        set_results_due.push_back(typed ? typed_res : r);
        requests_taken++;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_set_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (set_results_due.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected result: hit %0b refused %0b count %0d",
                             o_hit, o_full_refused, o_entry_count);
            end else begin
                want = set_results_due.pop_front();
                if (o_hit !== want.hit || o_full_refused !== want.refused ||
                    o_entry_count !== want.count) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("mismatch: exp hit %0b refused %0b count %0d, got %0b %0b %0d",
                                 want.hit, want.refused, want.count,
                                 o_hit, o_full_refused, o_entry_count);
                end
            end
        end
    end

    // Receiver back-pressure, with one long hold to fill the block up
    initial begin
        int  stall_left;
        int  cyc;
        bit  rx_bursty;
        bit  pressure_done;
        stall_left    = 0;
        cyc           = 0;
        rx_bursty     = 1'b1;
        pressure_done = 1'b0;
        in_long_hold  = 1'b0;
        i_out_stall  <= 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 150 == 0) rx_bursty = ($urandom_range(0, 3) != 0);
            if (stall_left == 0) begin
                in_long_hold = 1'b0;
                if (!pressure_done && requests_taken >= 60) begin
                    stall_left    = LONG_HOLD;
                    pressure_done = 1'b1;
                    in_long_hold  = 1'b1;
                end else if (!calm && rx_bursty && $urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 18);
                end
            end
            i_out_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
        end
    end

    initial begin
        t_stim_row                       stim_rows [DIRECTED_N];
        logic [mst_pkg::KEY_FIELD_W-1:0] key_pool [KEY_POOL_N];
        logic [mst_pkg::REQ_W-1:0]       req;
        logic [mst_pkg::KEY_FIELD_W-1:0] key;
        int                              ins_bias;
        int                              pick;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_req_type     = mst_pkg::REQ_INSERT;
        i_key          = '0;
        bad_results    = 0;
        requests_taken = 0;
        calm           = 1'b0;
        tx_bursty      = 1'b1;

        stim_rows = '{
            '{mst_pkg::REQ_QUERY,  32'h0000_0000,  1, 1, '{1'b0, 1'b0, 5'd0}},
            '{mst_pkg::REQ_REMOVE, 32'h0000_0000,  1, 1, '{1'b0, 1'b0, 5'd0}},
            '{REQ_SPARE,           32'hFFFF_FFFF,  1, 1, '{1'b0, 1'b0, 5'd0}},
            '{mst_pkg::REQ_INSERT, 32'h0000_0000,  1, 1, '{1'b1, 1'b0, 5'd1}},
            '{mst_pkg::REQ_INSERT, 32'h0000_0000,  1, 1, '{1'b0, 1'b0, 5'd1}},  // already held
            '{mst_pkg::REQ_INSERT, 32'hFFFF_FFFF,  1, 1, '{1'b1, 1'b0, 5'd2}},
            '{mst_pkg::REQ_QUERY,  32'hFFFF_FFFF,  1, 1, '{1'b1, 1'b0, 5'd2}},
            '{mst_pkg::REQ_QUERY,  32'hFFFF_FFFE,  1, 0, '{1'b0, 1'b0, 5'd0}},
            '{REQ_SPARE,           32'h0000_0000,  1, 1, '{1'b0, 1'b0, 5'd2}},
            '{mst_pkg::REQ_REMOVE, 32'h0000_0000,  1, 1, '{1'b1, 1'b0, 5'd1}},
            '{mst_pkg::REQ_QUERY,  32'hFFFF_FFFF,  1, 1, '{1'b1, 1'b0, 5'd1}},
            '{mst_pkg::REQ_INSERT, 32'h0000_0100, 15, 0, '{1'b0, 1'b0, 5'd0}},  // fills it
            '{mst_pkg::REQ_INSERT, 32'hDEAD_BEEF,  1, 1, '{1'b0, 1'b1, 5'd16}}, // refused
            '{mst_pkg::REQ_INSERT, 32'h0000_0105,  1, 1, '{1'b0, 1'b0, 5'd16}}, // full, held
            '{mst_pkg::REQ_QUERY,  32'h0000_010E,  1, 0, '{1'b0, 1'b0, 5'd0}},
            '{mst_pkg::REQ_REMOVE, 32'h0000_0107,  1, 1, '{1'b1, 1'b0, 5'd15}},
            '{mst_pkg::REQ_INSERT, 32'hAAAA_AAAA,  1, 1, '{1'b1, 1'b0, 5'd16}},
            '{mst_pkg::REQ_REMOVE, 32'hFFFF_FFFF,  1, 0, '{1'b0, 1'b0, 5'd0}},  // first entry
            '{mst_pkg::REQ_REMOVE, 32'hAAAA_AAAA,  1, 0, '{1'b0, 1'b0, 5'd0}},  // last entry
            '{mst_pkg::REQ_QUERY,  32'h0000_0108,  1, 0, '{1'b0, 1'b0, 5'd0}},
            '{mst_pkg::REQ_REMOVE, 32'h0000_0107,  1, 0, '{1'b0, 1'b0, 5'd0}},
            '{REQ_SPARE,           32'h5555_5555,  1, 0, '{1'b0, 1'b0, 5'd0}}
        };
        foreach (key_pool[i]) key_pool[i] = $urandom;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_rows[r])
            for (int j = 0; j < stim_rows[r].span; j++)
                offer_request(stim_rows[r].req, stim_rows[r].key + j,
                              stim_rows[r].typed && stim_rows[r].span == 1, stim_rows[r].res);

        ins_bias = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // every 120 requests a new insert bias is drawn, so phases fill or drain the table
            if (n % 120 == 0) begin
                ins_bias  = $urandom_range(15, 85);
                tx_bursty = ($urandom_range(0, 3) != 0);
                key_pool[$urandom_range(0, KEY_POOL_N - 1)] = $urandom;
            end
            calm = (n >= RANDOM_ITEMS - CALM_TAIL);
            pick = $urandom_range(0, 99);
            if (pick < 2)
                req = REQ_SPARE;
            else if (pick < ins_bias)
                req = mst_pkg::REQ_INSERT;
            else if ($urandom_range(0, 1) == 0)
                req = mst_pkg::REQ_REMOVE;
            else
                req = mst_pkg::REQ_QUERY;
            if ($urandom_range(0, 9) == 0)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
            offer_request(req, key, 1'b0, '0);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (set_results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (bad_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
sv/mst_pkg.sv
sv/mst_cell.sv
sv/membership_set_table_unit.sv
tb/sv/tb.sv
